[rtl/lmrb_pkg.sv]
// Shared types and constants for the layered mask rectangle blitter.
package lmrb_pkg;

  // Default geometry
  localparam int DEF_SCREEN_WIDTH  = 640;
  localparam int DEF_SCREEN_HEIGHT = 240;
  localparam int DEF_LAYER_COUNT   = 4;

  // Mask store word width in pixels
  localparam int WORD_BITS = 32;

  // Command codes
  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Source format register values
  localparam logic FMT_PIXEL   = 1'b0;
  localparam logic FMT_ROWMASK = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN_RD,
    ST_SPAN_WR,
    ST_RD_MEM,
    ST_RD_OUT
  } state_t;

  // Input item
  typedef struct packed {
    cmd_t        command;
    logic [9:0]  pos_x;
    logic [8:0]  pos_y;
    logic [9:0]  rect_width;
    logic [8:0]  rect_height;
    logic [1:0]  layer_index;
    logic [31:0] data_word;
  } in_payload_t;

  // Result item
  typedef struct packed {
    logic       mask_bit;
    logic [3:0] layers_used;
  } out_payload_t;

  // One horizontal span being written, word by word
  typedef struct packed {
    logic [10:0] xs;        // first column
    logic [10:0] xe;        // column past the last
    logic [5:0]  w;         // current store word within the row
    logic [1:0]  wcnt;      // words done in this row, saturating at 2
    logic        row_mode;  // 1: bits come from the row mask pattern
    logic        val;       // constant bit when not in row mode
    logic [63:0] pat;       // row mask aligned to the first word
  } span_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic       valid;
    logic       mask_bit;
    logic [3:0] layers_used;
  } res_t;

endpackage

[rtl/layered_mask_rect_blitter_top.sv]
// Top level of the layered mask rectangle blitter: sequencer plus output register.
// Begin is taken while idle; a read captures the store word, then its bit, then hands the result
// to the output register once that is free; a pixel word, row mask or fill reads, then merges and
// writes back, each touched 32-pixel store word. A new command is taken only once the last is done.
// Reset: synchronous; then a clearing pass zeroes all LAYER_COUNT * 2^ceil(log2 SCREEN_HEIGHT) *
// 2^ceil(log2 words per row) store words (32768 at defaults) with in_stall high.
module layered_mask_rect_blitter_top #(
  parameter int SCREEN_WIDTH  = lmrb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = lmrb_pkg::DEF_SCREEN_HEIGHT,
  parameter int LAYER_COUNT   = lmrb_pkg::DEF_LAYER_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lmrb_pkg::in_payload_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lmrb_pkg::out_payload_t out_data,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data
);

  lmrb_pkg::res_t        res;
  logic                  out_free;
  logic                  out_valid_r;
  lmrb_pkg::out_payload_t out_data_r;

  // Output slot free when empty or transferring this cycle
  assign out_free = !out_valid_r || !out_stall;

  lmrb_engine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .LAYER_COUNT   (LAYER_COUNT)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_free    (out_free),
    .res         (res)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r.mask_bit    <= res.mask_bit;
      out_data_r.layers_used <= res.layers_used;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/lmrb_span_merge.sv]
// Per-word bit enable and value for a span, merged into the word read back.
module lmrb_span_merge (
  input  lmrb_pkg::span_t sp,
  input  logic [31:0]     rdata,
  output logic [31:0]     wdata,
  output logic            last_word
);

  logic [10:0] xe_m1;
  logic [4:0]  lo;
  logic [4:0]  hi;
  logic [31:0] mask;
  logic [31:0] value;

  // Column range covered inside the current word
  always_comb begin
    xe_m1     = sp.xe - 11'd1;
    last_word = (sp.w == xe_m1[10:5]);
    lo        = (sp.w == sp.xs[10:5]) ? sp.xs[4:0] : 5'd0;
    hi        = last_word ? xe_m1[4:0] : 5'd31;
    mask      = ({32{1'b1}} << lo) & ({32{1'b1}} >> (5'd31 - hi));
  end

  // Source bits: constant, or the row mask; columns 32 and past read clear
  always_comb begin
    if (sp.row_mode) begin
      case (sp.wcnt)
        2'd0:    value = sp.pat[31:0];
        2'd1:    value = sp.pat[63:32];
        default: value = '0;
      endcase
    end else begin
      value = {32{sp.val}};
    end
  end

  assign wdata = (rdata & ~mask) | (value & mask);

endmodule

[rtl/lmrb_engine.sv]
// Command sequencer and mask store with read-modify-write of 32-pixel words.
module lmrb_engine #(
  parameter int SCREEN_WIDTH  = lmrb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = lmrb_pkg::DEF_SCREEN_HEIGHT,
  parameter int LAYER_COUNT   = lmrb_pkg::DEF_LAYER_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lmrb_pkg::in_payload_t in_data,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  out_free,
  output lmrb_pkg::res_t        res
);

  localparam int WPR    = (SCREEN_WIDTH + lmrb_pkg::WORD_BITS - 1) / lmrb_pkg::WORD_BITS;
  localparam int LB     = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int YB     = $clog2(SCREEN_HEIGHT);
  localparam int XWB    = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int ADDR_W = LB + YB + XWB;
  localparam int DEPTH  = LAYER_COUNT << (YB + XWB);

  localparam logic [10:0]       SCR_W     = 11'(SCREEN_WIDTH);
  localparam logic [9:0]        SCR_H     = 10'(SCREEN_HEIGHT);
  localparam logic [2:0]        LAY_N     = 3'(LAYER_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Store address: layer, row, word within row
  function automatic logic [ADDR_W-1:0] mk_addr(logic [1:0] l, logic [9:0] y,
                                                logic [5:0] w);
    return {l[LB-1:0], y[YB-1:0], w[XWB-1:0]};
  endfunction

  lmrb_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              fmt_r, fmt_nxt;
  logic [3:0]        used_r, used_nxt;
  logic [9:0]        rect_x0_r, rect_x0_nxt;
  logic [10:0]       rect_x1_r, rect_x1_nxt;
  logic [9:0]        rect_y1_r, rect_y1_nxt;
  logic [1:0]        rect_layer_r, rect_layer_nxt;
  logic [10:0]       cursor_x_r, cursor_x_nxt;
  logic [9:0]        cursor_y_r, cursor_y_nxt;
  lmrb_pkg::span_t   sp_r, sp_nxt;
  logic [9:0]        sp_y_r, sp_y_nxt;
  logic [9:0]        sp_ye_r, sp_ye_nxt;
  logic [1:0]        sp_layer_r, sp_layer_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [4:0]        rd_sel_r, rd_sel_nxt;
  logic              rd_bit_r, rd_bit_nxt;

  // Mask store ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [31:0]       mem_rdata_r;
  logic [31:0]       mem [DEPTH];

  // Decode of the offered item and the open rectangle
  logic        acc;
  logic        layer_ok;
  logic [10:0] fill_x1, fill_xe, rx_e;
  logic [9:0]  fill_y1, fill_ye, ry_e;
  logic        fill_go, pix_go, row_adv, row_paint, rd_ok_in;
  logic [10:0] cx_inc;
  logic [31:0] merged;
  logic        last_word;
  logic        more_rows;

  assign acc      = in_valid && (state_r == lmrb_pkg::ST_IDLE);
  assign in_stall = (state_r != lmrb_pkg::ST_IDLE);

  always_comb begin
    layer_ok  = ({1'b0, in_data.layer_index} < LAY_N);
    fill_x1   = {1'b0, in_data.pos_x} + {1'b0, in_data.rect_width};
    fill_y1   = {1'b0, in_data.pos_y} + {1'b0, in_data.rect_height};
    fill_xe   = (fill_x1 < SCR_W) ? fill_x1 : SCR_W;
    fill_ye   = (fill_y1 < SCR_H) ? fill_y1 : SCR_H;
    fill_go   = layer_ok && ({1'b0, in_data.pos_x} < fill_xe)
                && ({1'b0, in_data.pos_y} < fill_ye);
    rx_e      = (rect_x1_r < SCR_W) ? rect_x1_r : SCR_W;
    ry_e      = (rect_y1_r < SCR_H) ? rect_y1_r : SCR_H;
    pix_go    = (fmt_r == lmrb_pkg::FMT_PIXEL) && (cursor_x_r < rx_e)
                && (cursor_y_r < ry_e);
    row_adv   = (fmt_r == lmrb_pkg::FMT_ROWMASK) && (cursor_y_r < rect_y1_r);
    row_paint = row_adv && (cursor_y_r < SCR_H) && ({1'b0, rect_x0_r} < rx_e);
    rd_ok_in  = layer_ok && ({1'b0, in_data.pos_x} < SCR_W)
                && ({1'b0, in_data.pos_y} < SCR_H);
    cx_inc    = cursor_x_r + 11'd1;
    more_rows = (sp_y_r + 10'd1) < sp_ye_r;
  end

  lmrb_span_merge u_merge (
    .sp        (sp_r),
    .rdata     (mem_rdata_r),
    .wdata     (merged),
    .last_word (last_word)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lmrb_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) state_nxt = lmrb_pkg::ST_IDLE;
      end
      lmrb_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_data.command)
            lmrb_pkg::CMD_BEGIN: state_nxt = lmrb_pkg::ST_IDLE;
            lmrb_pkg::CMD_FILL: begin
              if (fill_go) state_nxt = lmrb_pkg::ST_SPAN_RD;
            end
            lmrb_pkg::CMD_DATA: begin
              if (pix_go || row_paint) state_nxt = lmrb_pkg::ST_SPAN_RD;
            end
            lmrb_pkg::CMD_READ: state_nxt = lmrb_pkg::ST_RD_MEM;
            default: state_nxt = lmrb_pkg::ST_IDLE;
          endcase
        end
      end
      lmrb_pkg::ST_SPAN_RD: state_nxt = lmrb_pkg::ST_SPAN_WR;
      lmrb_pkg::ST_SPAN_WR: begin
        if (last_word && !more_rows) state_nxt = lmrb_pkg::ST_IDLE;
        else                         state_nxt = lmrb_pkg::ST_SPAN_RD;
      end
      lmrb_pkg::ST_RD_MEM: state_nxt = lmrb_pkg::ST_RD_OUT;
      lmrb_pkg::ST_RD_OUT: begin
        if (out_free) state_nxt = lmrb_pkg::ST_IDLE;
      end
      default: state_nxt = lmrb_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and store controls
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    fmt_nxt        = cfg_wr_en ? cfg_wr_data : fmt_r;
    used_nxt       = used_r;
    rect_x0_nxt    = rect_x0_r;
    rect_x1_nxt    = rect_x1_r;
    rect_y1_nxt    = rect_y1_r;
    rect_layer_nxt = rect_layer_r;
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    sp_nxt         = sp_r;
    sp_y_nxt       = sp_y_r;
    sp_ye_nxt      = sp_ye_r;
    sp_layer_nxt   = sp_layer_r;
    rd_ok_nxt      = rd_ok_r;
    rd_sel_nxt     = rd_sel_r;
    rd_bit_nxt     = rd_bit_r;
    mem_we         = 1'b0;
    mem_waddr      = mk_addr(sp_layer_r, sp_y_r, sp_r.w);
    mem_wdata      = merged;
    mem_re         = 1'b0;
    mem_raddr      = mk_addr(sp_layer_r, sp_y_r, sp_r.w);
    res.valid       = 1'b0;
    res.mask_bit    = rd_bit_r;
    res.layers_used = used_r;

    unique case (state_r)
      lmrb_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      lmrb_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_data.command)
            // Open a rectangle; an absent layer closes it
            lmrb_pkg::CMD_BEGIN: begin
              if (layer_ok) begin
                used_nxt       = used_r | (4'b0001 << in_data.layer_index);
                rect_x0_nxt    = in_data.pos_x;
                rect_x1_nxt    = fill_x1;
                rect_y1_nxt    = fill_y1;
                rect_layer_nxt = in_data.layer_index;
                cursor_x_nxt   = {1'b0, in_data.pos_x};
                cursor_y_nxt   = {1'b0, in_data.pos_y};
              end else begin
                rect_x0_nxt    = '0;
                rect_x1_nxt    = '0;
                rect_y1_nxt    = '0;
                rect_layer_nxt = '0;
                cursor_x_nxt   = '0;
                cursor_y_nxt   = '0;
              end
            end
            // Fill walks every clipped row of the rectangle
            lmrb_pkg::CMD_FILL: begin
              if (layer_ok) used_nxt = used_r | (4'b0001 << in_data.layer_index);
              sp_nxt.xs       = {1'b0, in_data.pos_x};
              sp_nxt.xe       = fill_xe;
              sp_nxt.w        = in_data.pos_x[9:5] == 5'd0 ? 6'd0 : {1'b0, in_data.pos_x[9:5]};
              sp_nxt.wcnt     = 2'd0;
              sp_nxt.row_mode = 1'b0;
              sp_nxt.val      = 1'b1;
              sp_y_nxt        = {1'b0, in_data.pos_y};
              sp_ye_nxt       = fill_ye;
              sp_layer_nxt    = in_data.layer_index;
            end
            lmrb_pkg::CMD_DATA: begin
              sp_layer_nxt = rect_layer_r;
              sp_nxt.wcnt  = 2'd0;
              if (fmt_r == lmrb_pkg::FMT_PIXEL) begin
                // One pixel at the cursor, then step the walk
                sp_nxt.xs       = cursor_x_r;
                sp_nxt.xe       = cx_inc;
                sp_nxt.w        = cursor_x_r[10:5];
                sp_nxt.row_mode = 1'b0;
                sp_nxt.val      = |in_data.data_word[15:0];
                sp_y_nxt        = cursor_y_r;
                sp_ye_nxt       = cursor_y_r + 10'd1;
                if (pix_go) begin
                  if (cx_inc >= rx_e) begin
                    cursor_x_nxt = {1'b0, rect_x0_r};
                    cursor_y_nxt = cursor_y_r + 10'd1;
                  end else begin
                    cursor_x_nxt = cx_inc;
                  end
                end
              end else begin
                // Whole clipped row from the row mask
                sp_nxt.xs       = {1'b0, rect_x0_r};
                sp_nxt.xe       = rx_e;
                sp_nxt.w        = {1'b0, rect_x0_r[9:5]};
                sp_nxt.row_mode = 1'b1;
                sp_nxt.pat      = {32'd0, in_data.data_word} << rect_x0_r[4:0];
                sp_y_nxt        = cursor_y_r;
                sp_ye_nxt       = cursor_y_r + 10'd1;
                if (row_adv) cursor_y_nxt = cursor_y_r + 10'd1;
              end
            end
            lmrb_pkg::CMD_READ: begin
              mem_re     = 1'b1;
              mem_raddr  = rd_ok_in ? mk_addr(in_data.layer_index, {1'b0, in_data.pos_y},
                                              {1'b0, in_data.pos_x[9:5]}) : '0;
              rd_ok_nxt  = rd_ok_in;
              rd_sel_nxt = in_data.pos_x[4:0];
            end
            default: ;
          endcase
        end
      end
      lmrb_pkg::ST_SPAN_RD: begin
        mem_re = 1'b1;
      end
      // Merge and write back, then step to the next word or row
      lmrb_pkg::ST_SPAN_WR: begin
        mem_we = 1'b1;
        if (last_word) begin
          sp_y_nxt    = sp_y_r + 10'd1;
          sp_nxt.w    = sp_r.xs[10:5];
          sp_nxt.wcnt = 2'd0;
        end else begin
          sp_nxt.w    = sp_r.w + 6'd1;
          sp_nxt.wcnt = (sp_r.wcnt == 2'd2) ? 2'd2 : sp_r.wcnt + 2'd1;
        end
      end
      lmrb_pkg::ST_RD_MEM: begin
        rd_bit_nxt = rd_ok_r & mem_rdata_r[rd_sel_r];
      end
      lmrb_pkg::ST_RD_OUT: begin
        res.valid = out_free;
      end
      default: ;
    endcase
  end

  // Control and rectangle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lmrb_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      fmt_r        <= lmrb_pkg::FMT_PIXEL;
      used_r       <= '0;
      rect_x0_r    <= '0;
      rect_x1_r    <= '0;
      rect_y1_r    <= '0;
      rect_layer_r <= '0;
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      fmt_r        <= fmt_nxt;
      used_r       <= used_nxt;
      rect_x0_r    <= rect_x0_nxt;
      rect_x1_r    <= rect_x1_nxt;
      rect_y1_r    <= rect_y1_nxt;
      rect_layer_r <= rect_layer_nxt;
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
    end
  end

  // Span and read payload
  always_ff @(posedge clk) begin
    sp_r       <= sp_nxt;
    sp_y_r     <= sp_y_nxt;
    sp_ye_r    <= sp_ye_nxt;
    sp_layer_r <= sp_layer_nxt;
    rd_ok_r    <= rd_ok_nxt;
    rd_sel_r   <= rd_sel_nxt;
    rd_bit_r   <= rd_bit_nxt;
  end

  // Mask store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  // Store is written only by the clearing pass or a span write-back
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == lmrb_pkg::ST_CLEAR || state_r == lmrb_pkg::ST_SPAN_WR))
    else $error("mask store written outside clear or span write-back");

  // A span in progress stays nonempty and inside its rows
  a_span_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lmrb_pkg::ST_SPAN_RD) |->
      (sp_r.xs < sp_r.xe) && (sp_y_r < sp_ye_r) && (sp_r.xe <= SCR_W))
    else $error("span bounds broken");

  // Used flags only ever gain bits
  a_used_grow: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((used_r & $past(used_r)) == $past(used_r)))
    else $error("layer used flag cleared");

  // A result is only issued after the read data was captured
  a_res_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> $past(state_r) == lmrb_pkg::ST_RD_MEM
                  || $past(state_r) == lmrb_pkg::ST_RD_OUT)
    else $error("result without store read");
`endif

endmodule

[verif/layered_mask_rect_blitter_top_tb.sv]
// Self-checking testbench for the layered mask rectangle blitter: directed and random commands.
module layered_mask_rect_blitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int SCR_W       = lmrb_pkg::DEF_SCREEN_WIDTH;
  localparam int SCR_H       = lmrb_pkg::DEF_SCREEN_HEIGHT;
  localparam int LAYERS      = lmrb_pkg::DEF_LAYER_COUNT;
  localparam int IDLE_MAX    = 14;
  localparam int QUIET_LIMIT = 150000;  // covers the clearing pass and a full-screen fill
  localparam int PHASE_ITEMS = 205;
  localparam int MAX_REPORTS = 10;

  function automatic int imin(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // Mask predictor plus the queue of read results still owed by the block
  class blit_scoreboard;
    bit                     mask_q [LAYERS*SCR_H*SCR_W];
    logic [3:0]             used_q;
    int                     rx0, ry0, rx1, ry1, rlayer;
    int                     cur_x, cur_y;
    logic                   fmt_q;
    lmrb_pkg::out_payload_t pending_reads[$];
    int                     mismatches;

    function new();
      used_q     = '0;
      rx0        = 0;
      ry0        = 0;
      rx1        = 0;
      ry1        = 0;
      rlayer     = 0;
      cur_x      = 0;
      cur_y      = 0;
      fmt_q      = lmrb_pkg::FMT_PIXEL;
      mismatches = 0;
    endfunction

    function void set_format(logic f);
      fmt_q = f;
    endfunction

    // Off-screen pixels are never stored
    function void paint(int layer, int x, int y, bit v);
      if (x < SCR_W && y < SCR_H) mask_q[(layer*SCR_H + y)*SCR_W + x] = v;
    endfunction

    // Apply one accepted command; returns 0 for a data word past the end of the rectangle
    function bit note_command(lmrb_pkg::in_payload_t c);
      int                     x, y, xe, ye, k;
      bit                     hit;
      lmrb_pkg::out_payload_t want;
      hit = 1'b1;
      case (c.command)
        lmrb_pkg::CMD_BEGIN: begin
          used_q[c.layer_index] = 1'b1;
          rx0    = int'(c.pos_x);
          ry0    = int'(c.pos_y);
          rx1    = int'(c.pos_x) + int'(c.rect_width);
          ry1    = int'(c.pos_y) + int'(c.rect_height);
          rlayer = int'(c.layer_index);
          cur_x  = rx0;
          cur_y  = ry0;
        end
        lmrb_pkg::CMD_FILL: begin
          used_q[c.layer_index] = 1'b1;
          xe = imin(int'(c.pos_x) + int'(c.rect_width), SCR_W);
          ye = imin(int'(c.pos_y) + int'(c.rect_height), SCR_H);
          for (y = int'(c.pos_y); y < ye; y++)
            for (x = int'(c.pos_x); x < xe; x++) paint(int'(c.layer_index), x, y, 1'b1);
        end
        lmrb_pkg::CMD_DATA: begin
          xe = imin(rx1, SCR_W);
          if (fmt_q == lmrb_pkg::FMT_PIXEL) begin
            // one word per on-screen pixel, row by row
            ye = imin(ry1, SCR_H);
            if (cur_x < xe && cur_y < ye) begin
              paint(rlayer, cur_x, cur_y, c.data_word[15:0] != 16'd0);
              cur_x++;
              if (cur_x >= xe) begin
                cur_x = rx0;
                cur_y++;
              end
            end else begin
              hit = 1'b0;
            end
          end else if (cur_y < ry1) begin
            // one word per row; offsets past bit 31 paint clear
            for (x = rx0; x < xe; x++) begin
              k = x - rx0;
              paint(rlayer, x, cur_y, (k < 32) ? c.data_word[k] : 1'b0);
            end
            cur_y++;
          end else begin
            hit = 1'b0;
          end
        end
        default: begin
          want.mask_bit    = 1'b0;
          want.layers_used = used_q;
          if (c.pos_x < SCR_W && c.pos_y < SCR_H)
            want.mask_bit = mask_q[(int'(c.layer_index)*SCR_H + int'(c.pos_y))*SCR_W
                                   + int'(c.pos_x)];
          pending_reads.push_back(want);
        end
      endcase
      return hit;
    endfunction

    // Compare one result transfer with the oldest outstanding read
    function void check_read(lmrb_pkg::out_payload_t got);
      lmrb_pkg::out_payload_t want;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with no read outstanding: mask_bit=%0b layers_used=%h",
                   got.mask_bit, got.layers_used);
        return;
      end
      want = pending_reads.pop_front();
      if (got.mask_bit !== want.mask_bit || got.layers_used !== want.layers_used) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: read mismatch: expected mask_bit=%0b layers_used=%h, got %0b %h",
                   want.mask_bit, want.layers_used, got.mask_bit, got.layers_used);
      end
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  lmrb_pkg::in_payload_t  in_data     = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  lmrb_pkg::out_payload_t out_data;
  logic                   cfg_wr_en   = 1'b0;
  logic                   cfg_wr_data = 1'b0;

  blit_scoreboard sb;
  bit             idle_en         = 1'b1;
  int             hold_len        = 0;
  int             effective_items = 0;
  int             quiet_cycles    = 0;

  layered_mask_rect_blitter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  function automatic int draw_idle();
    return idle_en ? $urandom_range(0, IDLE_MAX) : 0;
  endfunction

  function automatic lmrb_pkg::in_payload_t make_cmd(lmrb_pkg::cmd_t op, int x, int y, int w,
                                                     int h, int lyr, logic [31:0] word);
    lmrb_pkg::in_payload_t c;
    c.command     = op;
    c.pos_x       = x[9:0];
    c.pos_y       = y[8:0];
    c.rect_width  = w[9:0];
    c.rect_height = h[8:0];
    c.layer_index = lyr[1:0];
    c.data_word   = word;
    return c;
  endfunction

  // Offer one command and hold it until the transfer; valid stays high for the next one
  task automatic send_cmd(input lmrb_pkg::in_payload_t c);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (sb.note_command(c)) effective_items++;
  endtask

  task automatic write_format(input logic f);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_format(f);
  endtask

  // A trailing read drains everything queued ahead of it, leaving the block idle
  task automatic settle_and_set_format(input logic f);
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, $urandom_range(0, SCR_W-1),
                      $urandom_range(0, SCR_H-1), 0, 0, $urandom_range(0, LAYERS-1), 32'd0));
    in_valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_format(f);
  endtask

  // Random traffic, mostly complete rectangles followed by reads into them
  task automatic run_phase(input int target);
    int          start, pick, x, y, w, h, n, full, cols, rows, i;
    int          lyr;
    logic [31:0] word;
    start = effective_items;
    while (effective_items - start < target) begin
      idle_en = ($urandom_range(0, 5) != 0);
      pick    = $urandom_range(0, 99);
      lyr     = $urandom_range(0, LAYERS-1);
      x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, SCR_W-1);
      y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, SCR_H-1);
      if (pick < 55) begin
        if (sb.fmt_q == lmrb_pkg::FMT_PIXEL) begin
          w = $urandom_range(0, 12);
          h = $urandom_range(0, 4);
        end else begin
          w = $urandom_range(0, 48);
          h = $urandom_range(0, 8);
        end
        send_cmd(make_cmd(lmrb_pkg::CMD_BEGIN, x, y, w, h, lyr, $urandom()));
        cols = imin(x + w, SCR_W) - x;
        rows = imin(y + h, SCR_H) - y;
        if (cols < 0) cols = 0;
        if (rows < 0) rows = 0;
        full = (sb.fmt_q == lmrb_pkg::FMT_PIXEL) ? cols * rows : h;
        // now and then cut the data short or run past the end
        n = full;
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(0, full);
          1:       n = full + $urandom_range(1, 3);
          default: ;
        endcase
        for (i = 0; i < n; i++) begin
          word = $urandom();
          case ($urandom_range(0, 5))
            0:       word[15:0] = 16'd0;
            1:       word = 32'hFFFF_FFFF;
            2:       word = 32'd0;
            default: ;
          endcase
          send_cmd(make_cmd(lmrb_pkg::CMD_DATA, $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), word));
        end
        for (i = $urandom_range(1, 3); i > 0; i--)
          send_cmd(make_cmd(lmrb_pkg::CMD_READ, x + $urandom_range(0, w),
                            y + $urandom_range(0, h), 0, 0,
                            ($urandom_range(0, 3) == 0) ? $urandom() : lyr, 32'd0));
      end else if (pick < 70) begin
        w = $urandom_range(0, 40);
        h = $urandom_range(0, 8);
        send_cmd(make_cmd(lmrb_pkg::CMD_FILL, x, y, w, h, lyr, $urandom()));
        send_cmd(make_cmd(lmrb_pkg::CMD_READ, x + $urandom_range(0, w),
                          y + $urandom_range(0, h), 0, 0, lyr, 32'd0));
      end else if (pick < 71) begin
        // rare large fill
        w = $urandom_range(0, 1023);
        h = $urandom_range(0, 511);
        send_cmd(make_cmd(lmrb_pkg::CMD_FILL, x, y, w, h, lyr, $urandom()));
        send_cmd(make_cmd(lmrb_pkg::CMD_READ, x + $urandom_range(0, w),
                          y + $urandom_range(0, h), 0, 0, lyr, 32'd0));
      end else if (pick < 88) begin
        send_cmd(make_cmd(lmrb_pkg::CMD_READ, x, y, $urandom(), $urandom(), lyr, $urandom()));
      end else begin
        send_cmd(make_cmd(lmrb_pkg::cmd_t'($urandom_range(0, 3)), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom()));
      end
    end
  endtask

  // Result side: random stall before each transfer, or one long hold-off on request
  initial begin : result_sink
    int gap;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      gap      = (hold_len > 0) ? hold_len : draw_idle();
      hold_len = 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_read(out_data);
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int p, i;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_format(lmrb_pkg::FMT_PIXEL);

    // Directed: empty store, clipping, zero size, pixel word rule, exhausted rectangle
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_FILL, 1023, 511, 1023, 511, 3, 32'hFFFF_FFFF));
    send_cmd(make_cmd(lmrb_pkg::CMD_FILL, 630, 235, 20, 10, 2, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 639, 239, 0, 0, 2, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_FILL, 5, 5, 0, 5, 1, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 5, 5, 0, 0, 1, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_BEGIN, 638, 10, 4, 2, 0, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'hFFFF_0000));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'h0000_8000));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'h0000_0001));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'h0000_FFFF));
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 638, 10, 0, 0, 0, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 639, 10, 0, 0, 0, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 1023, 511, 1023, 511, 3, 32'hFFFF_FFFF));

    // Format switch in the middle of a rectangle, then rows past bit 31 and below the screen
    send_cmd(make_cmd(lmrb_pkg::CMD_BEGIN, 0, 238, 40, 3, 3, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'h0000_FFFF));
    settle_and_set_format(lmrb_pkg::FMT_ROWMASK);
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'hAAAA_AAAA));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'h5555_5555));
    send_cmd(make_cmd(lmrb_pkg::CMD_DATA, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 31, 238, 0, 0, 3, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 32, 238, 0, 0, 3, 32'd0));
    send_cmd(make_cmd(lmrb_pkg::CMD_READ, 1, 239, 0, 0, 3, 32'd0));

    // Random phases, alternating the source format
    for (p = 0; p < 4; p++) begin
      settle_and_set_format(p[0] ? lmrb_pkg::FMT_ROWMASK : lmrb_pkg::FMT_PIXEL);
      if (p == 1) begin
        // back-to-back reads against a long result hold-off stall the input
        idle_en  = 1'b0;
        hold_len = 400;
        for (i = 0; i < 24; i++)
          send_cmd(make_cmd(lmrb_pkg::CMD_READ, $urandom_range(0, SCR_W-1),
                            $urandom_range(0, SCR_H-1), 0, 0,
                            $urandom_range(0, LAYERS-1), 32'd0));
      end
      run_phase(PHASE_ITEMS);
    end

    // Drain
    in_valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_reads.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
rtl/lmrb_pkg.sv
rtl/lmrb_span_merge.sv
rtl/lmrb_engine.sv
rtl/layered_mask_rect_blitter_top.sv
verif/layered_mask_rect_blitter_top_tb.sv
